### hw/rtl/assert_macros.svh
// Assertion macros for the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising edge once reset is released.
`define PST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check on every rising edge, reset included.
`define PST_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PST_ASSERT(label, prop)
`define PST_ASSERT_ALWAYS(label, prop)
`endif

`endif

### hw/rtl/pst_pkg.sv
// Package for the pan servo sweep tracker: beat types, sizes and constants.
`timescale 1ns / 1ps

package pst_pkg;

  // History sizing.
  localparam int HISTORY_LIMIT = 50;
  localparam int HIST_DEPTH    = HISTORY_LIMIT + 1;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int CNT_W         = $clog2(HIST_DEPTH + 1);

  // Angle range and widths.
  localparam int PAN_W   = 8;
  localparam int PAN_MAX = 180;
  localparam int SUM_W   = $clog2(HIST_DEPTH * PAN_MAX + 1);
  localparam int PHASE_W = 8;
  localparam int STOPS_W = 16;
  localparam int OFF_W   = 11;
  localparam int MS_W    = 16;

  // Behavior constants.
  localparam int TIMER_LIMIT = 1250;
  localparam int DEADBAND    = 6;
  localparam int SWEEP_LO    = 35;
  localparam int SWEEP_HI    = 155;
  localparam int JUMP_DEG    = 15;
  localparam int RECOVER_DEG = 3;
  localparam int PAN_CENTER  = 90;

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 8;
  localparam logic [CFG_AW-1:0] REG_SWEEP_PERIOD = 1'd0;
  localparam logic [CFG_AW-1:0] REG_SWEEP_PAUSED = 1'd1;
  localparam logic [CFG_DW-1:0] SWEEP_PERIOD_RST = 8'd2;

  // Input beat.
  typedef struct packed {
    logic signed [OFF_W-1:0] pc_offset;
    logic                    target_found;
    logic [MS_W-1:0]         ms_since_target;
  } pst_in_t;

  // Result beat.
  typedef struct packed {
    logic [PAN_W-1:0]   pan_angle;
    logic [PAN_W-1:0]   prior_pan;
    logic [PAN_W-1:0]   avg_pan;
    logic               pan_left;
    logic [STOPS_W-1:0] stop_count;
  } pst_out_t;

endpackage

### hw/rtl/pan_servo_sweep_tracker.sv
// Top level of the pan servo sweep tracker.
// Usage:
//   One input beat is one control tick: camera offset, target-found flag and
//   milliseconds since the target was registered. Each tick yields exactly
//   one result beat with the new pan angle, the prior angle, the history
//   average, the left/right flag and the jump-back count.
//   The input channel is taken while in_stall is low; in_stall stays high
//   from the accepting edge until the result is written into the output
//   register, so one tick is worked on at a time.
//   A tick passes through the history push, the history average, the sweep
//   period remainder and the angle update, in that order. The shared
//   restoring divider yields one quotient bit per cycle: 14 bits for the
//   history average and 8 bits for the sweep period remainder. The next
//   tick is taken only once the last result has entered the output register.
//   While out_stall holds a result, the block finishes the next tick up to
//   the final update and waits there until the output register is free.
//   Reset (rst_n low, synchronous) centers the pan at 90 degrees, empties
//   the history, restores the register defaults and drops any pending beat.
//   Configuration writes take effect on the edge where cfg_we is high.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pan_servo_sweep_tracker
  import pst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pst_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pst_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int DIV_W  = SUM_W;
  localparam int DVS_W  = (CNT_W > PHASE_W) ? CNT_W : PHASE_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam logic signed [9:0] ONE_S     = 10'sd1;
  localparam logic signed [9:0] JUMP_S    = 10'(JUMP_DEG);
  localparam logic [PAN_W-1:0]  RECOVER_U = PAN_W'(RECOVER_DEG);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PUSH = 5'b00010,
    S_AVG  = 5'b00100,
    S_MOD  = 5'b01000,
    S_UPD  = 5'b10000
  } state_t;

  // Clamp a signed angle to the servo range.
  function automatic logic [PAN_W-1:0] sat_pan(input logic signed [9:0] a);
    logic [PAN_W-1:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > PAN_MAX) begin
      r = PAN_W'(PAN_MAX);
    end else begin
      r = a[PAN_W-1:0];
    end
    return r;
  endfunction

  state_t                  state_r;
  pst_in_t                 in_r;
  logic [CFG_DW-1:0]       period_r;
  logic                    paused_r;
  logic [PAN_W-1:0]        pan_r, pan_nxt;
  logic [PAN_W-1:0]        pan_before_r, pan_before_nxt;
  logic signed [OFF_W-1:0] lo_r, lo_nxt;
  logic                    parity_r, parity_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic                    moved_r, moved_nxt;
  logic [STOPS_W-1:0]      stops_r, stops_nxt;
  logic [HIST_AW-1:0]      head_r;
  logic [CNT_W-1:0]        hist_cnt_r, hist_cnt_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [PAN_W-1:0]        hist_rdata;
  logic                    hist_full;
  logic [DIV_W-1:0]        dvd_r, dvd_step;
  logic [DVS_W-1:0]        dvs_r, rem_r, rem_step;
  logic [DVS_W:0]          trial;
  logic                    trial_ge;
  logic [STEP_W-1:0]       step_r;
  logic [PAN_W-1:0]        avg_r;
  logic [PAN_W-1:0]        sweep_a;
  logic signed [9:0]       pan_s;
  pst_out_t                out_r;
  logic                    out_valid_r;
  logic                    in_fire, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // History memory: read the slot at the head on accept, write it on push.
  pst_ram #(
    .WIDTH(PAN_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (state_r == S_PUSH),
    .waddr(head_r),
    .wdata(pan_r),
    .re   (in_fire),
    .raddr(head_r),
    .rdata(hist_rdata)
  );

  // When the history is full the head slot holds the oldest entry.
  assign hist_full    = (hist_cnt_r == CNT_W'(HIST_DEPTH));
  assign sum_nxt      = sum_r - (hist_full ? SUM_W'(hist_rdata) : '0) + SUM_W'(pan_r);
  assign hist_cnt_nxt = hist_full ? hist_cnt_r : hist_cnt_r + 1'b1;

  // One restoring division step, shared by the average and the period remainder.
  assign trial    = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});
  assign rem_step = trial_ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  assign dvd_step = {dvd_r[DIV_W-2:0], trial_ge};

  // Angle update for the tick, using the period remainder left in rem_r.
  always_comb begin
    pan_s          = signed'({2'b00, pan_r});
    pan_nxt        = pan_r;
    pan_before_nxt = pan_before_r;
    lo_nxt         = lo_r;
    parity_nxt     = parity_r;
    phase_nxt      = phase_r;
    moved_nxt      = moved_r;
    stops_nxt      = stops_r;
    sweep_a        = (lo_r < -DEADBAND || !parity_r) ? sat_pan(pan_s + ONE_S)
                                                     : sat_pan(pan_s - ONE_S);
    if (in_r.ms_since_target >= MS_W'(TIMER_LIMIT)) begin
      moved_nxt = 1'b0;
      if (in_r.target_found) begin
        // Center the target one degree at a time outside the deadband.
        if (in_r.pc_offset < -DEADBAND) begin
          pan_nxt = sat_pan(pan_s + ONE_S);
        end else if (in_r.pc_offset > DEADBAND) begin
          pan_nxt = sat_pan(pan_s - ONE_S);
        end
      end else if (!paused_r) begin
        // Sweep step, skipped when the phase is a multiple of the period.
        if (rem_r != '0) begin
          pan_nxt        = sweep_a;
          pan_before_nxt = sweep_a;
          if (sweep_a <= PAN_W'(SWEEP_LO) || sweep_a >= PAN_W'(SWEEP_HI)) begin
            parity_nxt = !parity_r;
            lo_nxt     = '0;
          end
          if (sweep_a > PAN_W'(SWEEP_HI)) begin
            pan_nxt = sweep_a - RECOVER_U;
          end else if (sweep_a < PAN_W'(SWEEP_LO)) begin
            pan_nxt = sweep_a + RECOVER_U;
          end
        end
        phase_nxt = phase_r + 1'b1;
      end
    end else if (!moved_r) begin
      // Jump back once toward the last seen offset.
      if (lo_r < -DEADBAND) begin
        pan_nxt = sat_pan(pan_s + JUMP_S);
      end else if (lo_r > DEADBAND) begin
        pan_nxt = sat_pan(pan_s - JUMP_S);
      end
      moved_nxt = 1'b1;
      stops_nxt = stops_r + 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= SWEEP_PERIOD_RST;
      paused_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SWEEP_PERIOD: period_r <= cfg_wdata;
        REG_SWEEP_PAUSED: paused_r <= cfg_wdata[0];
      endcase
    end
  end

  // Sequencer and tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pan_r        <= PAN_W'(PAN_CENTER);
      pan_before_r <= PAN_W'(PAN_CENTER);
      lo_r         <= '0;
      parity_r     <= 1'b0;
      phase_r      <= '0;
      moved_r      <= 1'b0;
      stops_r      <= '0;
      head_r       <= '0;
      hist_cnt_r   <= '0;
      sum_r        <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // The update state owns the result valid bit while it is active.
      if (out_valid_r && !out_stall && state_r != S_UPD) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.pc_offset != '0) begin
              lo_r <= in_data.pc_offset;
            end
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          sum_r      <= sum_nxt;
          hist_cnt_r <= hist_cnt_nxt;
          head_r     <= (head_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_r + 1'b1;
          step_r     <= STEP_W'(DIV_W);
          state_r    <= S_AVG;
        end
        S_AVG: begin
          if (step_r == STEP_W'(1)) begin
            step_r  <= STEP_W'(PHASE_W);
            state_r <= S_MOD;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_MOD: begin
          step_r <= step_r - 1'b1;
          if (step_r == STEP_W'(1)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            pan_r        <= pan_nxt;
            pan_before_r <= pan_before_nxt;
            lo_r         <= lo_nxt;
            parity_r     <= parity_nxt;
            phase_r      <= phase_nxt;
            moved_r      <= moved_nxt;
            stops_r      <= stops_nxt;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers: input latch, divider datapath and result beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    unique case (state_r)
      S_PUSH: begin
        dvd_r <= sum_nxt;
        dvs_r <= DVS_W'(hist_cnt_nxt);
        rem_r <= '0;
      end
      S_AVG: begin
        if (step_r == STEP_W'(1)) begin
          // Quotient is done; load the phase for the period remainder.
          avg_r <= dvd_step[PAN_W-1:0];
          dvd_r <= DIV_W'(phase_r) << (DIV_W - PHASE_W);
          dvs_r <= (period_r == '0) ? DVS_W'(1) : DVS_W'(period_r);
          rem_r <= '0;
        end else begin
          dvd_r <= dvd_step;
          rem_r <= rem_step;
        end
      end
      S_MOD: begin
        dvd_r <= dvd_step;
        rem_r <= rem_step;
      end
      S_UPD: begin
        if (out_free) begin
          out_r.pan_angle  <= pan_nxt;
          out_r.prior_pan  <= pan_before_nxt;
          out_r.avg_pan    <= avg_r;
          out_r.pan_left   <= (pan_nxt >= PAN_W'(PAN_CENTER));
          out_r.stop_count <= stops_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  // Assertions.
  `PST_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE)
  `PST_ASSERT(a_accept_push, in_fire |=> state_r == S_PUSH)
  `PST_ASSERT(a_hist_bound, hist_cnt_r <= CNT_W'(HIST_DEPTH))
  `PST_ASSERT(a_pan_range, pan_r <= PAN_W'(PAN_MAX))
  `PST_ASSERT(a_result_from_upd, $rose(out_valid_r) |-> $past(state_r == S_UPD))
  `PST_ASSERT(a_avg_range, out_valid_r |-> out_r.avg_pan <= PAN_W'(PAN_MAX))

endmodule

### hw/rtl/pst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 51
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the pan servo sweep tracker: directed and random ticks.
`timescale 1ns / 1ps

module tb_top;
  import pst_pkg::*;

  // Cycles without any accepted beat before the run is declared hung; the limit
  // also covers sender gaps and result stalls.
  localparam int WATCHDOG_LIMIT = 1000;
  // Quiet cycles after the last result.
  localparam int TAIL_CYCLES    = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pst_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pst_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  pan_servo_sweep_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the tracker state and its registers.
  int           pan_now_m    = PAN_CENTER;
  int           pan_before_m = PAN_CENTER;
  int           last_off_m   = 0;
  bit           parity_m     = 1'b0;
  int           phase_m      = 0;
  bit           moved_back_m = 1'b0;
  logic [15:0]  stops_m      = '0;
  logic [7:0]   hist_m [HIST_DEPTH];
  int           head_m       = 0;
  int           count_m      = 0;
  int           sum_m        = 0;
  logic [7:0]   period_m     = SWEEP_PERIOD_RST;
  bit           paused_m     = 1'b0;

  pst_out_t     pending_pans [$];
  bit           idle_on = 1'b1;
  int           errors = 0;
  int           ticks_sent = 0;
  int           results_checked = 0;
  int           settings_used = 0;
  int           recoveries_m = 0;

  function automatic int clamp_pan(input int a);
    if (a < 0) return 0;
    if (a > PAN_MAX) return PAN_MAX;
    return a;
  endfunction

  // Advances the shadow state by one tick and returns the result beat it yields.
  function automatic pst_out_t predict_pan(input pst_in_t t);
    int       off;
    int       ms;
    int       per;
    int       step;
    pst_out_t r;
    off = $signed(t.pc_offset);
    ms  = t.ms_since_target;
    if (off != 0) last_off_m = off;

    // Push the current angle, dropping the oldest entry once the ring is full.
    if (count_m > HISTORY_LIMIT) begin
      sum_m -= int'(hist_m[(head_m + HIST_DEPTH - count_m) % HIST_DEPTH]);
      count_m--;
    end
    hist_m[head_m] = pan_now_m[7:0];
    head_m = (head_m + 1) % HIST_DEPTH;
    count_m++;
    sum_m += pan_now_m;
    r.avg_pan = 8'(sum_m / count_m);

    if (ms >= TIMER_LIMIT) begin
      moved_back_m = 1'b0;
      if (t.target_found) begin
        // Centering moves one degree and leaves the prior angle alone.
        if (off < -DEADBAND) pan_now_m = clamp_pan(pan_now_m + 1);
        else if (off > DEADBAND) pan_now_m = clamp_pan(pan_now_m - 1);
      end else if (!paused_m) begin
        // A period of zero behaves like one: every sweep tick skips.
        per = (period_m == 0) ? 1 : int'(period_m);
        if (phase_m % per != 0) begin
          step = (last_off_m < -DEADBAND || !parity_m) ? 1 : -1;
          pan_now_m = clamp_pan(pan_now_m + step);
          pan_before_m = pan_now_m;
          if (pan_now_m <= SWEEP_LO || pan_now_m >= SWEEP_HI) begin
            parity_m = !parity_m;
            last_off_m = 0;
          end
          // Recovery records the angle it starts from.
          if (pan_now_m > SWEEP_HI) begin
            pan_before_m = pan_now_m;
            pan_now_m = clamp_pan(pan_now_m - RECOVER_DEG);
            recoveries_m++;
          end else if (pan_now_m < SWEEP_LO) begin
            pan_before_m = pan_now_m;
            pan_now_m = clamp_pan(pan_now_m + RECOVER_DEG);
            recoveries_m++;
          end
        end
        phase_m = (phase_m + 1) % 256;
      end
    end else if (!moved_back_m) begin
      // One jump back per low-timer stretch, even inside the deadband.
      if (last_off_m < -DEADBAND) pan_now_m = clamp_pan(pan_now_m + JUMP_DEG);
      else if (last_off_m > DEADBAND) pan_now_m = clamp_pan(pan_now_m - JUMP_DEG);
      moved_back_m = 1'b1;
      stops_m = stops_m + 16'd1;
    end

    r.pan_angle  = pan_now_m[7:0];
    r.prior_pan  = pan_before_m[7:0];
    r.pan_left   = (pan_now_m >= PAN_CENTER);
    r.stop_count = stops_m;
    return r;
  endfunction

  function automatic int rand_offset();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic logic [7:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3:       return 8'd2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one tick beat and records its expected result once accepted.
  task automatic send_tick(input int off, input bit found, input int ms);
    pst_in_t t;
    t.pc_offset       = off[OFF_W-1:0];
    t.target_found    = found;
    t.ms_since_target = ms[MS_W-1:0];
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    pending_pans.push_back(predict_pan(t));
    ticks_sent++;
  endtask

  // Any field value, with the timer often close to its threshold.
  task automatic send_random_tick();
    int ms;
    case ($urandom_range(0, 3))
      0:       ms = $urandom_range(0, 65535);
      1:       ms = $urandom_range(TIMER_LIMIT - 10, TIMER_LIMIT + 10);
      2:       ms = $urandom_range(0, TIMER_LIMIT - 1);
      default: ms = $urandom_range(TIMER_LIMIT, 65535);
    endcase
    send_tick(rand_offset(), 1'($urandom_range(0, 1)), ms);
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_pans.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers while the block is idle; upper pause bits are junk.
  task automatic configure_sweep(input logic [7:0] period, input bit paused);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SWEEP_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_addr  <= REG_SWEEP_PAUSED;
    cfg_wdata <= {7'($urandom_range(0, 127)), paused};
    @(posedge clk);
    cfg_we    <= 1'b0;
    period_m = period;
    paused_m = paused;
    settings_used++;
  endtask

  // Reset defaults: deadband hold, a skipped sweep tick, then a sweep step.
  task automatic test_reset_state();
    send_tick(0, 1'b1, TIMER_LIMIT);
    send_tick(0, 1'b0, TIMER_LIMIT);
    send_tick(0, 1'b0, TIMER_LIMIT);
  endtask

  // Offset and timer extremes and the deadband edges.
  task automatic test_field_extremes();
    send_tick(-1024, 1'b1, 65535);
    send_tick(1023, 1'b1, 65535);
    send_tick(-(DEADBAND + 1), 1'b1, TIMER_LIMIT);
    send_tick(DEADBAND + 1, 1'b1, TIMER_LIMIT);
    send_tick(-DEADBAND, 1'b1, TIMER_LIMIT + 50);
    send_tick(DEADBAND, 1'b1, TIMER_LIMIT + 50);
    // Jump back with the last offset inside the deadband: no move, still counted.
    send_tick(0, 1'b0, 0);
    send_tick(-1024, 1'b0, TIMER_LIMIT - 1);
    send_tick(0, 1'b1, TIMER_LIMIT);
  endtask

  // Jump back in both directions, only once per low-timer stretch.
  task automatic test_jump_back();
    send_tick(-(DEADBAND + 1), 1'b1, 100);
    send_tick(5, 1'b0, 200);
    send_tick(0, 1'b1, 2000);
    send_tick(800, 1'b1, 0);
  endtask

  // A zero period skips every sweep step; pausing stops the sweep entirely.
  task automatic test_zero_period();
    configure_sweep(8'd0, 1'b0);
    repeat (3) send_tick(0, 1'b0, 65535);
    configure_sweep(8'd255, 1'b1);
    repeat (2) send_tick(0, 1'b0, 5000);
    send_tick(0, 1'b1, 5000);
  endtask

  // Positions the pan with jump-backs, often past the sweep edges, then sweeps.
  task automatic test_sweep_passes(input int n);
    int stop_at;
    int dir;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      configure_sweep(($urandom_range(0, 2) == 0) ? pick_period()
                                                  : 8'($urandom_range(2, 255)),
                      $urandom_range(0, 5) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      dir = $urandom_range(0, 1) ? 1 : -1;
      repeat ($urandom_range(0, 8)) begin
        send_tick(dir * int'($urandom_range(DEADBAND + 1, 1023)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, TIMER_LIMIT - 1));
        send_tick(0, 1'b1, $urandom_range(TIMER_LIMIT, 65535));
      end
      repeat ($urandom_range(20, 120)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_random_tick();
        end else begin
          send_tick(($urandom_range(0, 6) == 0) ? rand_offset() : 0, 1'b0,
                    $urandom_range(TIMER_LIMIT, 65535));
        end
      end
    end
  endtask

  // Long centering runs toward one side, with deadband and reversed offsets.
  task automatic test_target_tracking(input int n);
    int stop_at;
    int dir;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      configure_sweep(pick_period(), 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      dir = $urandom_range(0, 1) ? 1 : -1;
      repeat ($urandom_range(10, 100)) begin
        case ($urandom_range(0, 9))
          0: send_random_tick();
          1: send_tick(dir * int'($urandom_range(0, DEADBAND)), 1'b1,
                       $urandom_range(TIMER_LIMIT, 65535));
          2: send_tick(-dir * int'($urandom_range(DEADBAND + 1, 1023)), 1'b1,
                       $urandom_range(TIMER_LIMIT, 65535));
          default: send_tick(dir * int'($urandom_range(DEADBAND + 1, 1023)), 1'b1,
                             $urandom_range(TIMER_LIMIT, 65535));
        endcase
      end
    end
  endtask

  // Low-timer stretches of one to three ticks, each closed by a high-timer tick.
  task automatic test_jump_trains(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      configure_sweep(pick_period(), 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(5, 30)) begin
        repeat ($urandom_range(1, 3)) begin
          send_tick(($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 12)) - DEADBAND
                                                : rand_offset(),
                    1'($urandom_range(0, 1)), $urandom_range(0, TIMER_LIMIT - 1));
        end
        send_tick(rand_offset(), 1'($urandom_range(0, 1)),
                  $urandom_range(TIMER_LIMIT, 65535));
      end
    end
  endtask

  // Fully random ticks under changing register settings.
  task automatic test_random_mix(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      configure_sweep(pick_period(), 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(50, 120)) send_random_tick();
    end
  endtask

  // Back-to-back beats with no gaps and no stalls, at the default settings.
  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    configure_sweep(SWEEP_PERIOD_RST, 1'b0);
    repeat (n) send_random_tick();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: random stall bursts and a field-by-field check of each beat.
  always @(posedge clk) begin : check_results
    static int stall_left = 0;
    pst_out_t  want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pans.size() == 0) begin
          errors++;
          $display("%0t: result beat with no tick pending: expected none, actual pan %0d",
                   $time, out_data.pan_angle);
        end else begin
          want = pending_pans.pop_front();
          check_field("pan_angle", 16'(want.pan_angle), 16'(out_data.pan_angle));
          check_field("prior_pan", 16'(want.prior_pan), 16'(out_data.prior_pan));
          check_field("avg_pan", 16'(want.avg_pan), 16'(out_data.avg_pan));
          check_field("pan_left", 16'(want.pan_left), 16'(out_data.pan_left));
          check_field("stop_count", want.stop_count, out_data.stop_count);
          results_checked++;
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      out_stall <= (stall_left > 0);
    end
  end

  // Hang detection: too long without a beat on either channel.
  always @(posedge clk) begin : watchdog
    static int quiet = 0;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results pending",
               $time, quiet, pending_pans.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_field_extremes();
    test_jump_back();
    test_zero_period();
    test_sweep_passes(700);
    test_target_tracking(400);
    test_jump_trains(350);
    test_random_mix(350);
    test_back_to_back(150);

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings and checked %0d results.",
             ticks_sent, settings_used, results_checked);
    $display("Run included %0d sweep edge recoveries and %0d jump-back moves.",
             recoveries_m, stops_m);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
